### src/dcs_pkg.sv
// Package for the drive commissioning sequencer: transaction types, drive
// states, status-word masks and the status-word decode function.
// No dependencies.
package dcs_pkg;

	localparam int JOINT_COUNT_DEF = 6;
	localparam int RETRY_W = 20;
	localparam logic [RETRY_W-1:0] RETRY_RESET = 20'd4000;

	localparam logic [2:0] ST_NOTREADY   = 3'd0;
	localparam logic [2:0] ST_SWDISABLED = 3'd1;
	localparam logic [2:0] ST_READY      = 3'd2;
	localparam logic [2:0] ST_SWITCHEDON = 3'd3;
	localparam logic [2:0] ST_ENABLED    = 3'd4;
	localparam logic [2:0] ST_QUICKSTOP  = 3'd5;
	localparam logic [2:0] ST_FAULTREACT = 3'd6;
	localparam logic [2:0] ST_FAULT      = 3'd7;

	localparam logic [15:0] MASK_4F = 16'h004F;
	localparam logic [15:0] MASK_6F = 16'h006F;

	localparam logic [15:0] SW_NOTREADY   = 16'h0000;
	localparam logic [15:0] SW_SWDISABLED = 16'h0040;
	localparam logic [15:0] SW_READY      = 16'h0021;
	localparam logic [15:0] SW_SWITCHEDON = 16'h0023;
	localparam logic [15:0] SW_ENABLED    = 16'h0027;
	localparam logic [15:0] SW_QUICKSTOP  = 16'h0007;
	localparam logic [15:0] SW_FAULTREACT = 16'h000F;
	localparam logic [15:0] SW_FAULT      = 16'h0008;

	localparam logic [15:0] CW_KEEP_SHUTDOWN = 16'h007E;
	localparam logic [15:0] CW_SET_SHUTDOWN  = 16'h0006;
	localparam logic [15:0] CW_KEEP_SWON     = 16'h0077;
	localparam logic [15:0] CW_SET_SWON      = 16'h0007;
	localparam logic [15:0] CW_KEEP_ENABLE   = 16'h007F;
	localparam logic [15:0] CW_SET_ENABLE    = 16'h000F;
	localparam logic [15:0] CW_FAULT_RESET   = 16'h0080;
	localparam logic [15:0] CW_KEEP_LOW      = 16'h00FF;

	typedef struct packed {
		logic        slave_operational;
		logic [15:0] drive_status;
		logic [15:0] ctrl_readback;
	} item_t;

	typedef struct packed {
		logic [2:0]  joint_index;
		logic        bring_up_phase;
		logic        write_control;
		logic [15:0] ctrl_cmd;
		logic [2:0]  drive_state;
		logic        all_enabled;
		logic        master_reset;
	} result_t;

	typedef struct packed {
		logic        hit;
		logic        wr;
		logic [15:0] ncw;
		logic [2:0]  st;
		logic        adv;
	} decode_t;

	// first match wins
	function automatic decode_t decode_status(input logic [15:0] sw, input logic [15:0] cw);
		decode_t d;
		logic [15:0] m4f;
		logic [15:0] m6f;
		m4f = sw & MASK_4F;
		m6f = sw & MASK_6F;
		d = '0;
		d.hit = 1'b1;
		if (m4f == SW_NOTREADY) begin
			d.st = ST_NOTREADY;
		end else if (m4f == SW_SWDISABLED) begin
			d.wr = 1'b1; d.ncw = (cw & CW_KEEP_SHUTDOWN) | CW_SET_SHUTDOWN; d.st = ST_SWDISABLED;
		end else if (m6f == SW_READY) begin
			d.wr = 1'b1; d.ncw = (cw & CW_KEEP_SWON) | CW_SET_SWON; d.st = ST_READY;
		end else if (m6f == SW_SWITCHEDON) begin
			d.wr = 1'b1; d.ncw = (cw & CW_KEEP_ENABLE) | CW_SET_ENABLE; d.st = ST_SWITCHEDON;
		end else if (m6f == SW_ENABLED) begin
			d.st = ST_ENABLED; d.adv = 1'b1;
		end else if (m6f == SW_QUICKSTOP) begin
			d.wr = 1'b1; d.ncw = (cw & CW_KEEP_ENABLE) | CW_SET_ENABLE; d.st = ST_QUICKSTOP;
		end else if (m4f == SW_FAULTREACT) begin
			d.wr = 1'b1; d.ncw = CW_FAULT_RESET; d.st = ST_FAULTREACT;
		end else if (m4f == SW_FAULT) begin
			d.wr = 1'b1; d.ncw = (cw & CW_KEEP_LOW) | CW_FAULT_RESET; d.st = ST_FAULT;
		end else begin
			d.hit = 1'b0;
		end
		return d;
	endfunction

endpackage

### src/drive_commissioning_sequencer_top.sv
// Top level of the drive commissioning sequencer.
// Depends on dcs_pkg (transaction types, state codes, status decode).

// One transaction in, one result out, one transaction accepted per clock
// while item_stall is low. An item passes an input register and is decoded
// into the result register when the output advances, which presents its
// result; joint pointer, phase, retry counter and per-joint drive states
// are updated on that same edge. The two registers give two transactions
// of buffering; once both registers hold a transaction, result_stall
// reaches item_stall in the same cycle.
// The retry_cycles register (reset 4000) is written through cfg_valid/cfg_ready
// and is always ready.
module drive_commissioning_sequencer_top #(
	parameter int JOINT_COUNT = dcs_pkg::JOINT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  dcs_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output dcs_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dcs_pkg::RETRY_W-1:0] cfg_data
);

	localparam int PW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int XW = (PW > 3) ? PW : 3;
	localparam logic [PW:0] LAST_NEXT = (PW + 1)'(JOINT_COUNT);

	logic [dcs_pkg::RETRY_W-1:0] retry_cycles_q;
	logic [dcs_pkg::RETRY_W-1:0] retry_counter_q;
	logic [dcs_pkg::RETRY_W-1:0] cnt;
	logic                        phase_q;
	logic [PW-1:0]               ptr_q;
	logic [2:0]                  joint_states_q [JOINT_COUNT];

	dcs_pkg::item_t   item_s1;
	logic             valid_s1_q;
	dcs_pkg::result_t result_s2;
	logic             result_valid_q;

	logic             advance;
	logic             take_item;
	dcs_pkg::decode_t dec;
	dcs_pkg::result_t res;
	logic [2:0]       st_cur;
	logic [2:0]       st_new;
	logic [PW:0]      ptr_inc;
	logic             step;
	logic             wrap;
	logic [PW-1:0]    ptr_next;
	logic [XW-1:0]    ptr_ext;

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1_q && !advance;
	assign take_item  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_s2;

	always_comb begin
		dec      = dcs_pkg::decode_status(item_s1.drive_status, item_s1.ctrl_readback);
		st_cur   = joint_states_q[ptr_q];
		ptr_inc  = {1'b0, ptr_q} + (PW + 1)'(1);
		cnt      = retry_counter_q + dcs_pkg::RETRY_W'(1);
		step     = phase_q ? dec.adv : item_s1.slave_operational;
		wrap     = step && (ptr_inc == LAST_NEXT);
		ptr_next = wrap ? '0 : (step ? ptr_inc[PW-1:0] : ptr_q);
		st_new   = (phase_q && dec.hit) ? dec.st : st_cur;
		ptr_ext  = XW'(ptr_q);

		res                  = '0;
		res.joint_index      = ptr_ext[2:0];
		res.bring_up_phase   = phase_q;
		res.drive_state      = st_new;
		if (phase_q) begin
			res.write_control    = dec.wr;
			res.ctrl_cmd         = dec.ncw;
			res.all_enabled      = wrap;
		end else begin
			res.master_reset     = (cnt >= retry_cycles_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q     <= 1'b0;
			result_valid_q <= 1'b0;
			retry_cycles_q <= dcs_pkg::RETRY_RESET;
			retry_counter_q <= '0;
			phase_q        <= 1'b0;
			ptr_q          <= '0;
			for (int i = 0; i < JOINT_COUNT; i++) begin
				joint_states_q[i] <= dcs_pkg::ST_NOTREADY;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				retry_cycles_q <= cfg_data;
			end
			if (advance) begin
				valid_s1_q     <= take_item;
				result_valid_q <= valid_s1_q;
			end else if (take_item) begin
				valid_s1_q <= 1'b1;
			end
			if (advance && valid_s1_q) begin
				ptr_q <= ptr_next;
				if (phase_q) begin
					joint_states_q[ptr_q] <= st_new;
				end else begin
					if (wrap) begin
						phase_q <= 1'b1;
					end
					retry_counter_q <= res.master_reset ? '0 : cnt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			item_s1 <= item;
		end
		if (advance && valid_s1_q) begin
			result_s2 <= res;
		end
	end

endmodule

### tb/sv/dcs_result_checker.sv
// Checker for the drive commissioning sequencer: watches the item, result
// and config channels, predicts each result and compares it field by field.
// Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_result_checker #(
	parameter int JOINT_COUNT = dcs_pkg::JOINT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  dcs_pkg::item_t              item,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  dcs_pkg::result_t            result,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [dcs_pkg::RETRY_W-1:0] cfg_data,
	output int                          outstanding,
	output int                          mismatches
);

	logic                        bring_up_done;
	int unsigned                 joint_ptr;
	logic [2:0]                  joint_state [JOINT_COUNT];
	logic [dcs_pkg::RETRY_W-1:0] retry_count;
	logic [dcs_pkg::RETRY_W-1:0] retry_limit;
	dcs_pkg::result_t            commission_results [$];

	initial begin
		outstanding = 0;
		mismatches  = 0;
	end

	function automatic dcs_pkg::result_t commission_step(input dcs_pkg::item_t it);
		dcs_pkg::result_t            r;
		int unsigned                 jp;
		int unsigned                 nxt;
		logic [2:0]                  st;
		logic [15:0]                 m4f;
		logic [15:0]                 m6f;
		logic [dcs_pkg::RETRY_W-1:0] cnt;
		jp  = (joint_ptr >= JOINT_COUNT) ? 0 : joint_ptr;
		st  = joint_state[jp];
		nxt = jp;
		r   = '0;
		r.joint_index    = jp[2:0];
		r.bring_up_phase = bring_up_done;
		if (!bring_up_done) begin
			if (it.slave_operational)
				nxt = jp + 1;
			if (nxt >= JOINT_COUNT) begin
				nxt = 0;
				bring_up_done = 1'b1;
			end
			cnt = retry_count + 1'b1;
			if (cnt >= retry_limit) begin
				r.master_reset = 1'b1;
				retry_count = '0;
			end else begin
				retry_count = cnt;
			end
		end else begin
			m4f = it.drive_status & dcs_pkg::MASK_4F;
			m6f = it.drive_status & dcs_pkg::MASK_6F;
			if (m4f == dcs_pkg::SW_NOTREADY) begin
				st = dcs_pkg::ST_NOTREADY;
			end else if (m4f == dcs_pkg::SW_SWDISABLED) begin
				r.write_control = 1'b1;
				r.ctrl_cmd = (it.ctrl_readback & dcs_pkg::CW_KEEP_SHUTDOWN)
					| dcs_pkg::CW_SET_SHUTDOWN;
				st = dcs_pkg::ST_SWDISABLED;
			end else if (m6f == dcs_pkg::SW_READY) begin
				r.write_control = 1'b1;
				r.ctrl_cmd = (it.ctrl_readback & dcs_pkg::CW_KEEP_SWON)
					| dcs_pkg::CW_SET_SWON;
				st = dcs_pkg::ST_READY;
			end else if (m6f == dcs_pkg::SW_SWITCHEDON) begin
				r.write_control = 1'b1;
				r.ctrl_cmd = (it.ctrl_readback & dcs_pkg::CW_KEEP_ENABLE)
					| dcs_pkg::CW_SET_ENABLE;
				st = dcs_pkg::ST_SWITCHEDON;
			end else if (m6f == dcs_pkg::SW_ENABLED) begin
				st = dcs_pkg::ST_ENABLED;
				nxt = jp + 1;
			end else if (m6f == dcs_pkg::SW_QUICKSTOP) begin
				r.write_control = 1'b1;
				r.ctrl_cmd = (it.ctrl_readback & dcs_pkg::CW_KEEP_ENABLE)
					| dcs_pkg::CW_SET_ENABLE;
				st = dcs_pkg::ST_QUICKSTOP;
			end else if (m4f == dcs_pkg::SW_FAULTREACT) begin
				r.write_control = 1'b1;
				r.ctrl_cmd = dcs_pkg::CW_FAULT_RESET;
				st = dcs_pkg::ST_FAULTREACT;
			end else if (m4f == dcs_pkg::SW_FAULT) begin
				r.write_control = 1'b1;
				r.ctrl_cmd = (it.ctrl_readback & dcs_pkg::CW_KEEP_LOW)
					| dcs_pkg::CW_FAULT_RESET;
				st = dcs_pkg::ST_FAULT;
			end
			joint_state[jp] = st;
			if (nxt >= JOINT_COUNT) begin
				nxt = 0;
				r.all_enabled = 1'b1;
			end
		end
		joint_ptr = nxt;
		r.drive_state = st;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [15:0] exp_val,
			input logic [15:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", field, exp_val, got_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dcs_pkg::result_t exp_r;
		if (!arst_n) begin
			bring_up_done = 1'b0;
			joint_ptr     = 0;
			retry_count   = '0;
			retry_limit   = dcs_pkg::RETRY_RESET;
			for (int i = 0; i < JOINT_COUNT; i++)
				joint_state[i] = dcs_pkg::ST_NOTREADY;
			commission_results.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				retry_limit = cfg_data;
			if (result_valid && !result_stall) begin
				if (commission_results.size() == 0) begin
					$error("result transaction with no prediction outstanding");
					mismatches++;
				end else begin
					exp_r = commission_results.pop_front();
					check_field("joint_index", 16'(exp_r.joint_index),
						16'(result.joint_index));
					check_field("bring_up_phase", 16'(exp_r.bring_up_phase),
						16'(result.bring_up_phase));
					check_field("write_control", 16'(exp_r.write_control),
						16'(result.write_control));
					check_field("ctrl_cmd", exp_r.ctrl_cmd, result.ctrl_cmd);
					check_field("drive_state", 16'(exp_r.drive_state),
						16'(result.drive_state));
					check_field("all_enabled", 16'(exp_r.all_enabled),
						16'(result.all_enabled));
					check_field("master_reset", 16'(exp_r.master_reset),
						16'(result.master_reset));
				end
			end
			if (item_valid && !item_stall)
				commission_results.push_back(commission_step(item));
		end
		outstanding = commission_results.size();
	end

endmodule

### tb/sv/drive_commissioning_sequencer_top_tb.sv
// Testbench top for the drive commissioning sequencer: clock, reset,
// stimulus and verdict. Depends on dcs_pkg, drive_commissioning_sequencer_top
// and dcs_result_checker.
`timescale 1ns / 1ps

module drive_commissioning_sequencer_top_tb;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        item_valid = 1'b0;
	logic                        item_stall;
	dcs_pkg::item_t              item = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	dcs_pkg::result_t            result;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [dcs_pkg::RETRY_W-1:0] cfg_data = '0;
	int                          outstanding;
	int                          mismatches;

	int unsigned idle_pct = 14;
	int unsigned stall_pct = 49;
	int unsigned sent = 0;
	int unsigned retry_writes = 0;

	drive_commissioning_sequencer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	dcs_result_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// well-formed status words of each drive state, with noise now and then
	function automatic dcs_pkg::item_t random_item();
		dcs_pkg::item_t it;
		int unsigned    pick;
		logic [15:0]    pat;
		logic [15:0]    msk;
		pick = $urandom_range(99);
		msk  = dcs_pkg::MASK_4F;
		if (pick < 30) begin
			pat = dcs_pkg::SW_ENABLED; msk = dcs_pkg::MASK_6F;
		end else if (pick < 40) begin
			pat = dcs_pkg::SW_NOTREADY;
		end else if (pick < 50) begin
			pat = dcs_pkg::SW_SWDISABLED;
		end else if (pick < 60) begin
			pat = dcs_pkg::SW_READY; msk = dcs_pkg::MASK_6F;
		end else if (pick < 70) begin
			pat = dcs_pkg::SW_SWITCHEDON; msk = dcs_pkg::MASK_6F;
		end else if (pick < 78) begin
			pat = dcs_pkg::SW_QUICKSTOP; msk = dcs_pkg::MASK_6F;
		end else if (pick < 84) begin
			pat = dcs_pkg::SW_FAULTREACT;
		end else if (pick < 90) begin
			pat = dcs_pkg::SW_FAULT;
		end else begin
			pat = '0; msk = '0;
		end
		it.slave_operational = 1'($urandom_range(1));
		it.drive_status      = (16'($urandom) & ~msk) | pat;
		it.ctrl_readback     = 16'($urandom);
		return it;
	endfunction

	// starts and ends at a falling edge; valid stays high unless a gap follows
	task automatic send_item(input dcs_pkg::item_t it);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct)
				@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_bring_up(input logic oper);
		dcs_pkg::item_t it;
		it = random_item();
		it.slave_operational = oper;
		send_item(it);
	endtask

	task automatic settle();
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_retry(input logic [dcs_pkg::RETRY_W-1:0] limit);
		item_valid <= 1'b0;
		settle();
		cfg_data  <= limit;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		retry_writes++;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// bring-up: reset limit, zero limit, small, max, then one on the entry cycle
		send_bring_up(1'b0);
		send_bring_up(1'b0);
		write_retry('0);
		send_bring_up(1'b0);
		send_bring_up(1'b1);
		write_retry(20'd3);
		send_bring_up(1'b0);
		send_bring_up(1'b0);
		send_bring_up(1'b0);
		send_bring_up(1'b1);
		send_bring_up(1'b1);
		write_retry(20'hFFFFF);
		send_bring_up(1'b1);
		send_bring_up(1'b0);
		write_retry(20'd1);
		send_bring_up(1'b1);
		send_bring_up(1'b1);

		// drive state decode, one of each plus unmatched words
		send_item('{1'b0, dcs_pkg::SW_NOTREADY, 16'hFFFF});
		send_item('{1'b1, dcs_pkg::SW_SWDISABLED, 16'hFFFF});
		send_item('{1'b0, dcs_pkg::SW_READY, 16'h0000});
		send_item('{1'b1, dcs_pkg::SW_SWITCHEDON, 16'hFFFF});
		send_item('{1'b0, dcs_pkg::SW_QUICKSTOP, 16'h0000});
		send_item('{1'b1, dcs_pkg::SW_FAULTREACT, 16'hFFFF});
		send_item('{1'b0, dcs_pkg::SW_FAULT, 16'hFFFF});
		send_item('{1'b1, 16'hFFFF, 16'hFFFF});
		send_item('{1'b0, 16'h0001, 16'h0000});
		for (int j = 0; j < dcs_pkg::JOINT_COUNT_DEF; j++)
			send_item('{j[0], dcs_pkg::SW_ENABLED | 16'hFF80, {16{j[0]}}});

		for (int seg = 0; seg < 3; seg++) begin
			idle_pct  = (seg == 0) ? 14 : (seg == 1) ? 49 : 0;
			stall_pct = (seg == 0) ? 49 : (seg == 1) ? 14 : 0;
			write_retry(20'($urandom_range(20'hFFFFF, 1)));
			repeat (250)
				send_item(random_item());
		end

		item_valid <= 1'b0;
		settle();
		repeat (8) @(negedge clk);
		$display("Bring-up under retry limits 0, 1, 3, reset and max, then drive state decode");
		$display("%0d input transactions, %0d retry-limit writes", sent, retry_writes);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
src/dcs_pkg.sv
src/drive_commissioning_sequencer_top.sv
tb/sv/dcs_result_checker.sv
tb/sv/drive_commissioning_sequencer_top_tb.sv
